// ===== rtl/ppla_pkg.sv =====
// Package for the passive port lease allocator: operation and status codes,
// controller states and the per-port slot record. No dependencies.
package ppla_pkg;

    localparam logic [1:0] OP_ALLOCATE = 2'd0;
    localparam logic [1:0] OP_RELEASE  = 2'd1;
    localparam logic [1:0] OP_CONNECT  = 2'd2;

    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_NONE    = 2'd1;
    localparam logic [1:0] ST_DONE    = 2'd2;

    localparam logic [15:0] DEFAULT_MIN_PORT = 16'd49152;
    localparam logic [15:0] DEFAULT_MAX_PORT = 16'd65534;
    localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
    localparam logic [23:0] DEFAULT_HOLD_MS  = 24'd240000;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL,
        S_OUT
    } state_t;

    // One peer slot; valid is held in the record, cleared by the reset sweep.
    typedef struct packed {
        logic        valid;
        logic [31:0] peer;
        logic [15:0] count;
        logic [47:0] expiry;
    } slot_t;

endpackage

// ===== rtl/ppla_ram.sv =====
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module ppla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read share one address; read data is registered and appears in the following cycle.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/passive_port_lease_allocator_unit.sv =====
// Passive port lease allocator top level: controller plus the per-port RAM.
// Depends on ppla_pkg and ppla_ram.
// Release/connect read the lease port's row, write it back, then give the result; a
// zero or out-of-range lease port or undefined operation skips the write. Allocate
// probes up to three passes of the range, one RAM read-modify-write per port whose
// connecting flag is clear. One request at a time. After reset a sweep clears the RAM.
module passive_port_lease_allocator_unit #(
    parameter int PORT_COUNT = 65536,
    parameter int PEER_SLOTS = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], peer_addr[33:2], start_port[49:34], lease_port[65:50],
    // connected[66], now_ms[114:67], zero fill to 120
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // granted_port[15:0], status[17:16], zero fill to 24
    output logic [23:0]  m_tdata
);
    localparam int AW = $clog2(PORT_COUNT);
    localparam int SW = $bits(ppla_pkg::slot_t);
    localparam int RW = 1 + PEER_SLOTS * SW;
    localparam int SIW = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam logic [15:0] TOP = 16'(PORT_COUNT - 1);
    localparam logic [1:0] CFG_EN = 2'd0, CFG_MIN = 2'd1, CFG_MAX = 2'd2, CFG_HOLD = 2'd3;

    // Config registers.
    logic        en_reg;
    logic [15:0] cmin_reg, cmax_reg;
    logic [23:0] hold_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg <= 1'b0; cmin_reg <= '0; cmax_reg <= '0;
            hold_reg <= ppla_pkg::DEFAULT_HOLD_MS;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_EN:   en_reg   <= cfg_wdata[0];
                CFG_MIN:  cmin_reg <= cfg_wdata[15:0];
                CFG_MAX:  cmax_reg <= cfg_wdata[15:0];
                CFG_HOLD: hold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Request latch.
    logic [1:0]  op_reg;
    logic [31:0] peer_reg;
    logic [15:0] lport_reg;
    logic        conn_reg;
    logic [47:0] now_reg;

    ppla_pkg::state_t state_reg, state_next;
    logic [15:0] port_reg, port_next, first_reg, first_next, lo_reg, hi_reg;
    logic [1:0]  phase_reg, phase_next;
    logic [AW-1:0] clr_reg;
    logic [15:0] gp_reg, gp_next;
    logic [1:0]  st_reg, st_next;

    // RAM: connecting flag in the top bit, then the slot records.
    logic          we;
    logic [AW-1:0] addr;
    logic [RW-1:0] wdata, rdata;
    ppla_ram #(.WIDTH(RW), .DEPTH(PORT_COUNT)) u_ram (
        .aclk(aclk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
    );

    // Range computation from config.
    logic [15:0] a_lo, a_hi, r_lo, r_hi;
    always_comb begin
        if (en_reg) begin
            a_lo = (cmin_reg > cmax_reg) ? cmax_reg : cmin_reg;
            a_hi = (cmin_reg > cmax_reg) ? cmin_reg : cmax_reg;
            if (a_lo == 16'd0) a_lo = 16'd1;
            if (a_hi == 16'd0) a_hi = 16'd1;
        end else begin
            a_lo = ppla_pkg::DEFAULT_MIN_PORT;
            a_hi = ppla_pkg::DEFAULT_MAX_PORT;
        end
        r_lo = (a_lo > TOP) ? TOP : a_lo;
        r_hi = (a_hi > TOP) ? TOP : a_hi;
    end

    // Per-slot evaluation of the read row.
    ppla_pkg::slot_t sl [PEER_SLOTS];
    ppla_pkg::slot_t nsl [PEER_SLOTS];
    logic [PEER_SLOTS-1:0] vld, hit;
    logic [47:0] exp_new;
    assign exp_new = now_reg + 48'(hold_reg);
    always_comb begin
        for (int s = 0; s < PEER_SLOTS; s++) begin
            sl[s] = rdata[s*SW +: SW];
            vld[s] = sl[s].valid;
            if (op_reg == ppla_pkg::OP_ALLOCATE && phase_reg == 2'd0 && sl[s].valid
                && sl[s].count == 16'd0 && sl[s].expiry < now_reg)
                vld[s] = 1'b0;
            hit[s] = vld[s] && sl[s].peer == peer_reg;
        end
    end

    logic in_range_l;
    assign in_range_l = lport_reg != 16'd0 && 32'(lport_reg) < PORT_COUNT;

    // Controller.
    always_comb begin
        logic found, freefound, grant, flag;
        logic [SIW-1:0] hs, fs;
        logic [15:0] np;
        state_next = state_reg; port_next = port_reg; first_next = first_reg;
        phase_next = phase_reg; gp_next = gp_reg; st_next = st_reg;
        we = 1'b0; addr = port_reg[AW-1:0]; wdata = rdata;
        found = 1'b0; freefound = 1'b0; grant = 1'b0; hs = '0; fs = '0;
        np = 16'd0; flag = 1'b0;
        for (int s = 0; s < PEER_SLOTS; s++) nsl[s] = sl[s];
        case (state_reg)
            ppla_pkg::S_CLEAR: begin
                addr = clr_reg; we = 1'b1; wdata = '0;
                if (32'(clr_reg) == PORT_COUNT - 1) state_next = ppla_pkg::S_IDLE;
            end
            ppla_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    phase_next = 2'd0;
                    if (s_tdata[1:0] == ppla_pkg::OP_ALLOCATE) begin
                        first_next = (s_tdata[49:34] >= r_lo && s_tdata[49:34] <= r_hi)
                                     ? s_tdata[49:34] : r_lo;
                    end else begin
                        first_next = s_tdata[65:50];
                    end
                    port_next = first_next;
                    state_next = ppla_pkg::S_READ;
                end
            end
            ppla_pkg::S_READ: begin
                if (op_reg == ppla_pkg::OP_ALLOCATE) begin
                    state_next = ppla_pkg::S_EVAL;
                end else if (op_reg == ppla_pkg::OP_RELEASE || op_reg == ppla_pkg::OP_CONNECT) begin
                    state_next = in_range_l ? ppla_pkg::S_EVAL : ppla_pkg::S_OUT;
                end else begin
                    state_next = ppla_pkg::S_OUT;
                end
                gp_next = 16'd0; st_next = ppla_pkg::ST_DONE;
            end
            ppla_pkg::S_EVAL: begin
                for (int s = PEER_SLOTS - 1; s >= 0; s--) begin
                    if (hit[s]) begin found = 1'b1; hs = SIW'(s); end
                    if (!vld[s]) begin freefound = 1'b1; fs = SIW'(s); end
                end
                if (op_reg == ppla_pkg::OP_ALLOCATE) begin
                    flag = rdata[RW-1];
                    if (!flag) begin
                        for (int s = 0; s < PEER_SLOTS; s++) nsl[s].valid = vld[s];
                        if (found) begin
                            if (phase_reg == 2'd2) begin
                                grant = 1'b1;
                                if (sl[hs].count != ppla_pkg::COUNT_MAX)
                                    nsl[hs].count = sl[hs].count + 16'd1;
                            end
                        end else if ((vld == '0 || phase_reg != 2'd0) && freefound) begin
                            grant = 1'b1;
                            nsl[fs].valid = 1'b1; nsl[fs].peer = peer_reg;
                            nsl[fs].count = 16'd1; nsl[fs].expiry = '0;
                        end
                        // Write back pruned slots; the flag is set only on a grant.
                        we = 1'b1;
                        wdata[RW-1] = grant;
                        for (int s = 0; s < PEER_SLOTS; s++) wdata[s*SW +: SW] = nsl[s];
                    end
                    if (grant) begin
                        gp_next = port_reg; st_next = ppla_pkg::ST_GRANTED;
                        state_next = ppla_pkg::S_OUT;
                    end else begin
                        np = port_reg + 16'd1;
                        if (port_reg == 16'hFFFF || np < lo_reg || np > hi_reg) np = lo_reg;
                        port_next = np;
                        state_next = ppla_pkg::S_READ;
                        if (np == first_reg) begin
                            if (phase_reg == 2'd2) begin
                                gp_next = 16'd0; st_next = ppla_pkg::ST_NONE;
                                state_next = ppla_pkg::S_OUT;
                            end else begin
                                phase_next = phase_reg + 2'd1;
                            end
                        end
                    end
                end else begin
                    we = 1'b1;
                    if (op_reg == ppla_pkg::OP_RELEASE) begin
                        if (found && sl[hs].count != 16'd0) begin
                            nsl[hs].count = sl[hs].count - 16'd1;
                            nsl[hs].expiry = exp_new;
                        end
                        for (int s = 0; s < PEER_SLOTS; s++) wdata[s*SW +: SW] = nsl[s];
                        if (!conn_reg) wdata[RW-1] = 1'b0;
                    end else begin
                        wdata[RW-1] = 1'b0;
                    end
                    state_next = ppla_pkg::S_OUT;
                end
            end
            ppla_pkg::S_OUT: begin
                if (m_tready) state_next = ppla_pkg::S_IDLE;
            end
            default: state_next = ppla_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ppla_pkg::S_CLEAR;
            clr_reg <= '0;
            phase_reg <= 2'd0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            if (state_reg == ppla_pkg::S_CLEAR) clr_reg <= clr_reg + 1'b1;
        end
        port_reg <= port_next; first_reg <= first_next;
        gp_reg <= gp_next; st_reg <= st_next;
        if (state_reg == ppla_pkg::S_IDLE && s_tvalid) begin
            op_reg <= s_tdata[1:0]; peer_reg <= s_tdata[33:2];
            lport_reg <= s_tdata[65:50];
            conn_reg <= s_tdata[66]; now_reg <= s_tdata[114:67];
            lo_reg <= r_lo; hi_reg <= r_hi;
        end
    end

    assign s_tready = state_reg == ppla_pkg::S_IDLE;
    assign m_tvalid = state_reg == ppla_pkg::S_OUT;
    assign m_tdata  = {6'd0, st_reg, gp_reg};

    // A grant always names a nonzero port.
    a_grant_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && st_reg == ppla_pkg::ST_GRANTED |-> gp_reg != 16'd0)
        else $error("grant of port 0");
    // Phase never passes the last loosening step.
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg != 2'd3) else $error("phase overflow");
    // A result stays until taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
endmodule

// ===== tb/ppla_tb_pkg.sv =====
`timescale 1ns / 1ps
// Testbench package: register indexes of the configuration port and the
// undefined operation code. Shared by the checker and the testbench top.
package ppla_tb_pkg;

    localparam logic [1:0] CFG_CUSTOM_ENABLE = 2'd0;
    localparam logic [1:0] CFG_CUSTOM_MIN    = 2'd1;
    localparam logic [1:0] CFG_CUSTOM_MAX    = 2'd2;
    localparam logic [1:0] CFG_HOLD_TIME     = 2'd3;

    localparam logic [1:0] OP_UNDEFINED = 2'd3;

endpackage

// ===== tb/lease_checker.sv =====
`timescale 1ns / 1ps
// Checker for the port lease allocator: follows register writes and accepted
// requests, predicts each answer and compares it. Depends on ppla_pkg, ppla_tb_pkg.
module lease_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [119:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [23:0]  m_tdata,
    output int           error_count,
    output int           pending,
    output int           grant_count,
    output int           refusal_count
);

    localparam int NPORTS = 65536;
    localparam int NSLOTS = 4;

    typedef struct {
        logic [15:0] port;
        logic [1:0]  status;
    } answer_t;

    answer_t expected_answers[$];

    // Shadow of the block's lease tables and registers.
    bit          busy_flag[NPORTS];
    bit          lease_valid[NPORTS*NSLOTS];
    logic [31:0] lease_peer[NPORTS*NSLOTS];
    logic [15:0] lease_count[NPORTS*NSLOTS];
    logic [47:0] lease_expiry[NPORTS*NSLOTS];
    logic        use_custom = 1'b0;
    logic [15:0] bound_a = '0;
    logic [15:0] bound_b = '0;
    logic [23:0] hold_ms = ppla_pkg::DEFAULT_HOLD_MS;

    function automatic int slot_of_peer(int port, logic [31:0] peer);
        for (int s = 0; s < NSLOTS; s++)
            if (lease_valid[port*NSLOTS+s] && lease_peer[port*NSLOTS+s] == peer)
                return s;
        return -1;
    endfunction

    // Scan for a port; returns 0 when the scan gives up.
    function automatic int scan_for_port(logic [31:0] peer, int start, logic [47:0] now);
        int lo, hi, t, first, port, pass, used, freeslot, s, i;
        if (use_custom) begin
            lo = int'(bound_a);
            hi = int'(bound_b);
            if (lo > hi) begin
                t = lo; lo = hi; hi = t;
            end
            if (lo == 0) lo = 1;
            if (hi == 0) hi = 1;
        end else begin
            lo = int'(ppla_pkg::DEFAULT_MIN_PORT);
            hi = int'(ppla_pkg::DEFAULT_MAX_PORT);
        end
        if (lo > NPORTS-1) lo = NPORTS-1;
        if (hi > NPORTS-1) hi = NPORTS-1;
        first = (start >= lo && start <= hi) ? start : lo;
        port = first;
        pass = 0;
        forever begin
            if (!busy_flag[port]) begin
                busy_flag[port] = 1'b1;
                used = 0;
                freeslot = -1;
                // The first pass drops released leases that have expired.
                if (pass == 0)
                    for (s = 0; s < NSLOTS; s++) begin
                        i = port*NSLOTS + s;
                        if (lease_valid[i] && lease_count[i] == 0 && lease_expiry[i] < now)
                            lease_valid[i] = 1'b0;
                    end
                for (s = 0; s < NSLOTS; s++)
                    if (lease_valid[port*NSLOTS+s]) used++;
                    else if (freeslot < 0) freeslot = s;
                s = slot_of_peer(port, peer);
                if (s >= 0) begin
                    if (pass >= 2) begin
                        i = port*NSLOTS + s;
                        if (lease_count[i] != ppla_pkg::COUNT_MAX) lease_count[i]++;
                        return port;
                    end
                end else if ((used == 0 || pass >= 1) && freeslot >= 0) begin
                    i = port*NSLOTS + freeslot;
                    lease_valid[i] = 1'b1;
                    lease_peer[i] = peer;
                    lease_count[i] = 16'd1;
                    lease_expiry[i] = '0;
                    return port;
                end
                busy_flag[port] = 1'b0;
            end
            port++;
            if (port < lo || port > hi) port = lo;
            if (port == first) begin
                pass++;
                if (pass > 2) return 0;
            end
        end
    endfunction

    function automatic answer_t predict_answer(logic [119:0] req);
        answer_t a;
        logic [1:0]  op;
        logic [31:0] peer;
        int lport, s, i;
        op = req[1:0];
        peer = req[33:2];
        lport = int'(req[65:50]);
        a.port = '0;
        a.status = ppla_pkg::ST_DONE;
        if (op == ppla_pkg::OP_ALLOCATE) begin
            a.port = 16'(scan_for_port(peer, int'(req[49:34]), req[114:67]));
            a.status = (a.port != 0) ? ppla_pkg::ST_GRANTED : ppla_pkg::ST_NONE;
        end else if (op == ppla_pkg::OP_RELEASE) begin
            if (lport != 0) begin
                s = slot_of_peer(lport, peer);
                if (s >= 0) begin
                    i = lport*NSLOTS + s;
                    if (lease_count[i] != 0) begin
                        lease_count[i]--;
                        lease_expiry[i] = req[114:67] + 48'(hold_ms);
                    end
                end
                if (!req[66]) busy_flag[lport] = 1'b0;
            end
        end else if (op == ppla_pkg::OP_CONNECT) begin
            if (lport != 0) busy_flag[lport] = 1'b0;
        end
        return a;
    endfunction

    initial begin
        error_count = 0;
        grant_count = 0;
        refusal_count = 0;
    end

    assign pending = expected_answers.size();

    // Answers are compared before new requests are predicted in the same cycle.
    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0) begin
                $error("unexpected answer: port %0d status %0d", m_tdata[15:0], m_tdata[17:16]);
                error_count++;
            end else begin
                e = expected_answers.pop_front();
                if (m_tdata[15:0] !== e.port) begin
                    $error("granted_port: expected %0d, actual %0d", e.port, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[17:16] !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, m_tdata[17:16]);
                    error_count++;
                end
                if (e.status == ppla_pkg::ST_GRANTED) grant_count++;
                if (e.status == ppla_pkg::ST_NONE) refusal_count++;
            end
        end
        if (aresetn && s_tvalid && s_tready)
            expected_answers = {expected_answers, predict_answer(s_tdata)};
        if (aresetn && cfg_we) begin
            case (cfg_index)
                ppla_tb_pkg::CFG_CUSTOM_ENABLE: use_custom = cfg_wdata[0];
                ppla_tb_pkg::CFG_CUSTOM_MIN:    bound_a = cfg_wdata[15:0];
                ppla_tb_pkg::CFG_CUSTOM_MAX:    bound_b = cfg_wdata[15:0];
                ppla_tb_pkg::CFG_HOLD_TIME:     hold_ms = cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for the port lease allocator: clock, reset, requests and
// register settings, with the checker beside the block. Depends on both packages.
module testbench;

    localparam int IDLE_LIMIT = 400000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [23:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [119:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [23:0]  m_tdata;

    int errors, pending, grants, refusals;
    int sent = 0;
    int idle_cycles = 0;
    int ready_left = 0;
    bit no_gaps = 0;
    int lo_port, hi_port;
    logic [47:0] clock_ms = '0;
    logic [31:0] peer_pool[6] = '{32'h0A000001, 32'h0A000002, 32'hC0A80101,
                                  32'h7F000001, 32'h00000000, 32'hFFFFFFFF};

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    passive_port_lease_allocator_unit dut (.*);

    lease_checker u_checker (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_wdata,
        .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready, .m_tdata,
        .error_count(errors), .pending(pending),
        .grant_count(grants), .refusal_count(refusals)
    );

    // Result side back-pressure: mostly ready, short stalls, rare long ones.
    always @(posedge aclk) begin
        int r;
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            r = $urandom_range(99);
            if (r < 70) begin
                m_tready <= 1'b1;
                ready_left <= $urandom_range(20, 1);
            end else if (r < 95) begin
                m_tready <= 1'b0;
                ready_left <= $urandom_range(3, 1);
            end else begin
                m_tready <= 1'b0;
                ready_left <= $urandom_range(60, 10);
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(logic [1:0] index, logic [23:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Applies one range setting and mirrors the resolved bounds for stimulus.
    task automatic set_range(bit custom, logic [15:0] a, logic [15:0] b, logic [23:0] hold);
        int t;
        write_reg(ppla_tb_pkg::CFG_CUSTOM_ENABLE, 24'(custom));
        write_reg(ppla_tb_pkg::CFG_CUSTOM_MIN, 24'(a));
        write_reg(ppla_tb_pkg::CFG_CUSTOM_MAX, 24'(b));
        write_reg(ppla_tb_pkg::CFG_HOLD_TIME, hold);
        if (custom) begin
            lo_port = int'(a);
            hi_port = int'(b);
            if (lo_port > hi_port) begin
                t = lo_port; lo_port = hi_port; hi_port = t;
            end
            if (lo_port == 0) lo_port = 1;
            if (hi_port == 0) hi_port = 1;
        end else begin
            lo_port = int'(ppla_pkg::DEFAULT_MIN_PORT);
            hi_port = int'(ppla_pkg::DEFAULT_MAX_PORT);
        end
    endtask

    // Holds one request until accepted, then maybe idles the channel.
    task automatic send_request(logic [1:0] op, logic [31:0] peer, logic [15:0] start,
                                logic [15:0] lport, logic conn, logic [47:0] now);
        int r, gap;
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, now, conn, lport, start, peer, op};
        do @(posedge aclk); while (!s_tready);
        sent++;
        r = $urandom_range(99);
        gap = no_gaps ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(3, 1)
                                                    : $urandom_range(40, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain;
        if (s_tvalid) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        wait (pending == 0);
        repeat (10) @(posedge aclk);
    endtask

    // Random requests aimed at a few ports near the bottom of the range.
    task automatic random_requests(int count);
        int r, span;
        logic [1:0]  op;
        logic [31:0] peer;
        logic [15:0] start, lport;
        span = (hi_port - lo_port < 8) ? hi_port - lo_port : 8;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            op = (r < 50) ? ppla_pkg::OP_ALLOCATE
               : (r < 80) ? ppla_pkg::OP_RELEASE
               : (r < 96) ? ppla_pkg::OP_CONNECT : ppla_tb_pkg::OP_UNDEFINED;
            peer = ($urandom_range(9) == 0) ? $urandom() : peer_pool[$urandom_range(5)];
            r = $urandom_range(9);
            start = (r == 0) ? 16'($urandom()) : 16'(lo_port + $urandom_range(span));
            r = $urandom_range(19);
            lport = (r == 0) ? 16'($urandom()) : (r == 1) ? 16'd0
                                               : 16'(lo_port + $urandom_range(span));
            r = $urandom_range(49);
            if (r == 0) clock_ms = {$urandom(), 16'($urandom())};
            else clock_ms = clock_ms + 48'($urandom_range(300000));
            send_request(op, peer, start, lport, 1'($urandom_range(1)), clock_ms);
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        set_range(1'b0, 16'd0, 16'd0, ppla_pkg::DEFAULT_HOLD_MS);

        // Directed: every operation, field extremes, out-of-range start and lease ports.
        send_request(ppla_pkg::OP_ALLOCATE, 32'h0, 16'd0, 16'd0, 1'b0, 48'd0);
        send_request(ppla_pkg::OP_ALLOCATE, 32'hFFFFFFFF, 16'hFFFF, 16'd0, 1'b0, 48'd0);
        send_request(ppla_pkg::OP_ALLOCATE, 32'h0, 16'd49152, 16'd0, 1'b0, 48'd1);
        send_request(ppla_pkg::OP_ALLOCATE, 32'h0, 16'd65534, 16'd0, 1'b0, 48'd1);
        send_request(ppla_pkg::OP_RELEASE, 32'h0, 16'd0, 16'd49152, 1'b1, 48'd10);
        send_request(ppla_pkg::OP_RELEASE, 32'h0, 16'd0, 16'd49152, 1'b0, 48'd10);
        send_request(ppla_pkg::OP_RELEASE, 32'h0, 16'd0, 16'd49152, 1'b0, 48'd20);
        send_request(ppla_pkg::OP_CONNECT, 32'h0, 16'd0, 16'd65534, 1'b0, 48'd30);
        send_request(ppla_pkg::OP_RELEASE, 32'hFFFFFFFF, 16'hFFFF, 16'd0, 1'b1,
                     48'hFFFFFFFFFFFF);
        send_request(ppla_pkg::OP_CONNECT, 32'h0, 16'd0, 16'd0, 1'b0, 48'd40);
        send_request(ppla_pkg::OP_CONNECT, 32'h0, 16'd0, 16'hFFFF, 1'b1, 48'd40);
        send_request(ppla_tb_pkg::OP_UNDEFINED, 32'hFFFFFFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                     48'hFFFFFFFFFFFF);
        send_request(ppla_pkg::OP_RELEASE, 32'hFFFFFFFF, 16'd0, 16'd0, 1'b0, 48'd50);
        send_request(ppla_pkg::OP_ALLOCATE, 32'h0, 16'd49152, 16'd0, 1'b0,
                     48'hFFFFFFFFFFFF);
        send_request(ppla_pkg::OP_ALLOCATE, 32'h12345678, 16'd49153, 16'd0, 1'b0,
                     48'hFFFFFFFFFFFF);
        clock_ms = 48'd1000;
        random_requests(45);
        drain();

        // A small custom range fills up, so sharing, reuse and refusals occur.
        set_range(1'b1, 16'd200, 16'd203, 24'd1000);
        random_requests(150);
        drain();
        no_gaps = 1;
        set_range(1'b1, 16'd7, 16'd4, 24'd0);
        random_requests(100);
        drain();
        no_gaps = 0;
        set_range(1'b1, 16'd0, 16'd2, 24'hFFFFFF);
        random_requests(80);
        drain();
        set_range(1'b1, 16'd0, 16'd0, 24'd500);
        random_requests(40);
        drain();
        set_range(1'b1, 16'd65533, 16'd65535, 24'd5000);
        random_requests(80);
        drain();
        set_range(1'b0, 16'hFFFF, 16'hFFFF, ppla_pkg::DEFAULT_HOLD_MS);
        random_requests(40);
        drain();

        $display("Ran %0d requests over seven range and hold time settings.", sent);
        $display("Allocations granted %0d times and refused %0d times.", grants, refusals);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ppla_pkg.sv
rtl/ppla_ram.sv
rtl/passive_port_lease_allocator_unit.sv
tb/ppla_tb_pkg.sv
tb/lease_checker.sv
tb/testbench.sv
